// ----- rtl/chebm_pkg.sv -----
// ----------------------------------------------------------------------------
// Chebyshev (x-1)^2 multiplier package
// Shared coefficient width, request and response payloads, and the row
// classes that select the stencil weights.
// ----------------------------------------------------------------------------
`default_nettype none

package chebm_pkg;

   // Coefficients are signed Q8.24 at this width.
   localparam int COEF_WIDTH = 32;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   // Five stencil taps, c_{i-2} at index 0 through c_{i+2} at index 4.
   typedef coef_type [4:0] taps_type;

   typedef struct packed {
      coef_type coef_in;
      logic     is_last;
   } req_type;

   typedef struct packed {
      coef_type coef_out;
      logic     last_out;
   } rsp_type;

   // Rows 0 to 2 carry their own weights; every later row uses the general set.
   typedef enum logic [1:0] {
      ROW_ZERO    = 2'd0,
      ROW_ONE     = 2'd1,
      ROW_TWO     = 2'd2,
      ROW_GENERAL = 2'd3
   } row_class_type;

endpackage : chebm_pkg

`default_nettype wire

// ----- rtl/chebm_row.sv -----
// ----------------------------------------------------------------------------
// Chebyshev (x-1)^2 row evaluator
// Forms one result row from five taps in exact quarter units with
// shift-and-add weights, then floors by four and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module chebm_row (
   input  var chebm_pkg::taps_type      taps,
   input  var chebm_pkg::row_class_type row_class,
   output var chebm_pkg::coef_type      coef
);
   import chebm_pkg::*;

   // Weights sum to at most 20 in magnitude, so six guard bits suffice.
   localparam int GUARD = 6;
   localparam int SW    = COEF_WIDTH + GUARD;

   logic signed [SW-1:0] e0, e1, e2, e3, e4;
   logic signed [SW-1:0] p0, p1, p2, p3, p4;
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] floored;

   // Sign-extend the taps to the accumulation width.
   assign e0 = {{GUARD{taps[0][COEF_WIDTH-1]}}, taps[0]};
   assign e1 = {{GUARD{taps[1][COEF_WIDTH-1]}}, taps[1]};
   assign e2 = {{GUARD{taps[2][COEF_WIDTH-1]}}, taps[2]};
   assign e3 = {{GUARD{taps[3][COEF_WIDTH-1]}}, taps[3]};
   assign e4 = {{GUARD{taps[4][COEF_WIDTH-1]}}, taps[4]};

   // Per-tap weighted terms, in quarters of the coefficient LSB.
   always_comb begin
      unique case (row_class)
         ROW_ZERO: begin
            p0 = '0;
            p1 = '0;
            p2 = (e2 <<< 2) + (e2 <<< 1);
         end
         ROW_ONE: begin
            p0 = '0;
            p1 = -(e1 <<< 3);
            p2 = (e2 <<< 3) - e2;
         end
         ROW_TWO: begin
            p0 = e0 <<< 1;
            p1 = -(e1 <<< 2);
            p2 = (e2 <<< 2) + (e2 <<< 1);
         end
         ROW_GENERAL: begin
            p0 = e0;
            p1 = -(e1 <<< 2);
            p2 = (e2 <<< 2) + (e2 <<< 1);
         end
      endcase
   end

   assign p3 = -(e3 <<< 2);
   assign p4 = e4;

   // Exact sum, then floor division by four.
   assign sum     = p0 + p1 + p2 + p3 + p4;
   assign floored = sum >>> 2;

   // Saturate when the guard bits disagree with the result sign.
   always_comb begin
      if (&floored[SW-1:COEF_WIDTH-1] || ~|floored[SW-1:COEF_WIDTH-1]) begin
         coef = floored[COEF_WIDTH-1:0];
      end else if (floored[SW-1]) begin
         coef = {1'b1, {(COEF_WIDTH-1){1'b0}}};
      end else begin
         coef = {1'b0, {(COEF_WIDTH-1){1'b1}}};
      end
   end

endmodule : chebm_row

`default_nettype wire

// ----- rtl/chebyshev_mult_x_minus_one_squared_unit.sv -----
// ----------------------------------------------------------------------------
// Chebyshev (x-1)^2 multiplier unit
// Streams a run of Chebyshev coefficients and returns the coefficients of
// (x-1)^2 times the series through a five-tap banded stencil.
// ----------------------------------------------------------------------------
// Pipeline: the request that completes a stencil is registered in the input stage,
//   and its result then in the output register; results lag two requests behind.
// Throughput: one request per cycle unless the output stalls; a last request
//   holds the input stage for each final row, up to three, while the run flushes.
// Reset: synchronous; clears the window, position count, flush offset and both valid flags.
`default_nettype none

module chebyshev_mult_x_minus_one_squared_unit (
   input  var logic               clock,
   input  var logic               reset,
   input  var logic               req_valid,
   output var logic               req_stall,
   input  var chebm_pkg::req_type req_data,
   output var logic               rsp_valid,
   input  var logic               rsp_stall,
   output var chebm_pkg::rsp_type rsp_data
);
   import chebm_pkg::*;

   // Run state: last four coefficients, newest at index 0.
   coef_type [3:0] window_ff, window_in;
   logic [2:0]     count_ff, count_in;

   // Input stage: stencil snapshot of the accepted request.
   logic           s1_valid_ff, s1_valid_in;
   coef_type [4:0] s1_ext_ff, s1_ext_in;
   logic [2:0]     s1_k_ff, s1_k_in;
   logic           s1_last_ff, s1_last_in;
   logic [1:0]     s1_d_ff, s1_d_in;

   // Output register.
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic           req_accept;
   logic           out_free;
   logic           emit;
   logic           s1_step;
   logic           s1_done;
   logic [3:0]     row_index;
   row_class_type  row_class;
   taps_type       taps;
   coef_type       row_coef;

   // Handshake control.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = s1_last_ff || (s1_k_ff >= 3'd2);
   assign s1_step    = s1_valid_ff && (!emit || out_free);
   assign s1_done    = s1_step && (!s1_last_ff || (s1_d_ff == 2'd2));
   assign req_stall  = s1_valid_ff && !s1_done;
   assign req_accept = req_valid && !req_stall;

   // Window and count update; a last request starts a fresh run.
   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      if (req_accept) begin
         if (req_data.is_last) begin
            window_in = '0;
            count_in  = '0;
         end else begin
            window_in = {window_ff[2:0], req_data.coef_in};
            count_in  = (count_ff == 3'd7) ? 3'd7 : count_ff + 3'd1;
         end
      end
   end

   // Input stage load, flush stepping and retirement.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ext_in   = s1_ext_ff;
      s1_k_in     = s1_k_ff;
      s1_last_in  = s1_last_ff;
      s1_d_in     = s1_d_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_ext_in   = {req_data.coef_in, window_ff[0], window_ff[1],
                        window_ff[2], window_ff[3]};
         s1_k_in     = count_ff;
         s1_last_in  = req_data.is_last;
         // Rows before row zero do not exist, so a short run skips ahead.
         if (req_data.is_last && (count_ff < 3'd2)) begin
            s1_d_in = 2'd2 - count_ff[1:0];
         end else begin
            s1_d_in = 2'd0;
         end
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end else if (s1_step) begin
         s1_d_in = s1_d_ff + 2'd1;
      end
   end

   // Tap selection for the current flush offset; terms past the end are zero.
   always_comb begin
      unique case (s1_d_ff)
         2'd0:    taps = s1_ext_ff;
         2'd1:    taps = {coef_type'(0), s1_ext_ff[4:1]};
         2'd2:    taps = {coef_type'(0), coef_type'(0), s1_ext_ff[4:2]};
         default: taps = '0;
      endcase
   end

   // Row class from the row number k + d - 2.
   assign row_index = {1'b0, s1_k_ff} + {2'b00, s1_d_ff};

   always_comb begin
      priority if (row_index >= 4'd5) begin
         row_class = ROW_GENERAL;
      end else if (row_index == 4'd4) begin
         row_class = ROW_TWO;
      end else if (row_index == 4'd3) begin
         row_class = ROW_ONE;
      end else begin
         row_class = ROW_ZERO;
      end
   end

   chebm_row u_row (
      .taps      (taps),
      .row_class (row_class),
      .coef      (row_coef)
   );

   // Output register load.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff && emit;
         rsp_data_in  = '{coef_out: row_coef,
                          last_out: s1_last_ff && (s1_d_ff == 2'd2)};
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s1_d_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         s1_d_ff      <= s1_d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_ext_ff   <= s1_ext_in;
      s1_k_ff     <= s1_k_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The flush offset never passes the third row of a last request.
   a_flush_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_d_ff != 2'd3))
      else $error("flush offset out of range");

   // No new request enters while the final rows are still being flushed.
   a_flush_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && (s1_d_ff != 2'd2)) |-> req_stall)
      else $error("request accepted during flush");

   // A last request leaves the run state cleared.
   a_run_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.is_last) |=> ((count_ff == 3'd0) && (window_ff == '0)))
      else $error("run state not cleared after last request");

   // When it is taken, the final flush step yields a valid response marked last.
   a_last_source: assert property (@(posedge clock) disable iff (reset)
      (out_free && s1_valid_ff && s1_last_ff && (s1_d_ff == 2'd2)) |=>
         (rsp_valid_ff && rsp_data_ff.last_out))
      else $error("final row lost or unmarked");

endmodule : chebyshev_mult_x_minus_one_squared_unit

`default_nettype wire
